FILE: sv/pssu_pkg.sv
// Shared types, register codes and rounding helpers for the particle steering unit.
package pssu_pkg;

    typedef enum logic [1:0] {
        REG_BLEND_RATIO     = 2'd0,
        REG_ARRIVE_DISTANCE = 2'd1,
        REG_SCREEN_WIDTH    = 2'd2,
        REG_SCREEN_HEIGHT   = 2'd3
    } cfg_reg_t;

    localparam logic [16:0] BLEND_RATIO_RST     = 17'd32768;
    localparam logic [23:0] ARRIVE_DISTANCE_RST = 24'd2560;
    localparam logic [15:0] SCREEN_WIDTH_RST    = 16'd1024;
    localparam logic [15:0] SCREEN_HEIGHT_RST   = 16'd768;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam int UNIT_W = 18;  // signed Q.16 unit component, magnitude up to 1.0
    localparam int Q_BITS = 17;  // quotient bits of the unit divider

    typedef struct packed {
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [23:0] trail_x;
        logic signed [23:0] trail_y;
        logic [31:0]        new_age;
        logic               near_attractor;
        logic               expired;
    } res_t;

    typedef struct packed {
        res_t               res;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [15:0]        speed;
    } rec_t;

    typedef struct packed {
        res_t        res;
        logic [15:0] speed;
    } mid_t;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -48'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    // Divide by 2^sh, rounding half away from zero.
    function automatic logic signed [47:0] round_shr(input logic signed [47:0] v,
                                                     input int sh);
        logic [47:0] mag;
        logic [47:0] q;
        mag = v[47] ? 48'(-v) : 48'(v);
        q   = (mag + (48'd1 << (sh - 1))) >> sh;
        return v[47] ? -$signed(q) : $signed(q);
    endfunction

endpackage

FILE: sv/pssu_queue.sv
// Small FIFO of classified particle records between front and back.
module pssu_queue
    import pssu_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  rec_t                     push_data,
    input  logic                     pop,
    output rec_t                     head,
    output logic                     empty,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int AW = $clog2(DEPTH);

    rec_t                mem_reg [0:DEPTH-1];
    logic [AW-1:0]       wr_ptr_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [AW:0]         count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

FILE: sv/pssu_front.sv
// Front part: position advance, trail, ageing, expiry and near test.
module pssu_front
    import pssu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] vel_x,
    input  logic signed [23:0] vel_y,
    input  logic signed [23:0] attractor_x,
    input  logic signed [23:0] attractor_y,
    input  logic [15:0]        speed,
    input  logic [31:0]        age,
    input  logic [31:0]        lifetime,
    input  logic [15:0]        time_step,
    input  logic [23:0]        arrive_distance,
    input  logic [15:0]        screen_width,
    input  logic [15:0]        screen_height,
    output logic               push,
    output rec_t               push_data,
    output logic [2:0]         inflight
);

    // stage 1: velocity times step
    logic               s1_vld_reg;
    logic signed [40:0] s1_mx_reg, s1_my_reg;
    logic signed [23:0] s1_px_reg, s1_py_reg, s1_ax_reg, s1_ay_reg, s1_vx_reg, s1_vy_reg;
    logic [15:0]        s1_speed_reg, s1_ts_reg;
    logic [31:0]        s1_age_reg, s1_life_reg;

    // stage 2: positions, age, expiry
    logic               s2_vld_reg;
    logic signed [23:0] s2_nx_reg, s2_ny_reg, s2_tx_reg, s2_ty_reg;
    logic signed [23:0] s2_ax_reg, s2_ay_reg, s2_vx_reg, s2_vy_reg;
    logic [15:0]        s2_speed_reg;
    logic [31:0]        s2_nage_reg;
    logic               s2_exp_reg;

    logic signed [23:0] nx_next, ny_next, tx_next, ty_next;
    logic [32:0]        age_sum;
    logic [31:0]        nage_next;
    logic               exp_next;

    // stage 3: offset to attractor; stage 4: squares
    logic               s3_vld_reg, s4_vld_reg;
    rec_t               s3_rec_reg, s4_rec_reg;
    logic [48:0]        s4_dx2_reg, s4_dy2_reg;
    logic [47:0]        s4_ar2_reg;
    logic signed [49:0] dx2_full, dy2_full;
    rec_t               s3_rec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mx_reg    <= vel_x * $signed({1'b0, time_step});
        s1_my_reg    <= vel_y * $signed({1'b0, time_step});
        s1_px_reg    <= pos_x;
        s1_py_reg    <= pos_y;
        s1_ax_reg    <= attractor_x;
        s1_ay_reg    <= attractor_y;
        s1_vx_reg    <= vel_x;
        s1_vy_reg    <= vel_y;
        s1_speed_reg <= speed;
        s1_ts_reg    <= time_step;
        s1_age_reg   <= age;
        s1_life_reg  <= lifetime;
    end

    always_comb
    begin
        nx_next   = sat24(48'(s1_px_reg) + round_shr(48'(s1_mx_reg), 8));
        ny_next   = sat24(48'(s1_py_reg) + round_shr(48'(s1_my_reg), 8));
        tx_next   = sat24(48'(s1_px_reg) + round_shr(48'(s1_mx_reg), 10));
        ty_next   = sat24(48'(s1_py_reg) + round_shr(48'(s1_my_reg), 10));
        age_sum   = {1'b0, s1_age_reg} + 33'(s1_ts_reg);
        nage_next = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
        // the edge itself stays alive
        exp_next  = (nage_next > s1_life_reg)
                 || nx_next[23] || ({1'b0, nx_next[22:0]} > {screen_width, 8'd0})
                 || ny_next[23] || ({1'b0, ny_next[22:0]} > {screen_height, 8'd0});
    end

    always_ff @(posedge clk)
    begin
        s2_nx_reg    <= nx_next;
        s2_ny_reg    <= ny_next;
        s2_tx_reg    <= tx_next;
        s2_ty_reg    <= ty_next;
        s2_nage_reg  <= nage_next;
        s2_exp_reg   <= exp_next;
        s2_ax_reg    <= s1_ax_reg;
        s2_ay_reg    <= s1_ay_reg;
        s2_vx_reg    <= s1_vx_reg;
        s2_vy_reg    <= s1_vy_reg;
        s2_speed_reg <= s1_speed_reg;
    end

    always_comb
    begin
        s3_rec_next                    = '0;
        s3_rec_next.res.new_pos_x      = s2_nx_reg;
        s3_rec_next.res.new_pos_y      = s2_ny_reg;
        s3_rec_next.res.trail_x        = s2_tx_reg;
        s3_rec_next.res.trail_y        = s2_ty_reg;
        s3_rec_next.res.new_age        = s2_nage_reg;
        s3_rec_next.res.expired        = s2_exp_reg;
        s3_rec_next.res.near_attractor = 1'b0;
        s3_rec_next.vel_x              = s2_vx_reg;
        s3_rec_next.vel_y              = s2_vy_reg;
        s3_rec_next.dx                 = 25'(s2_ax_reg) - 25'(s2_nx_reg);
        s3_rec_next.dy                 = 25'(s2_ay_reg) - 25'(s2_ny_reg);
        s3_rec_next.speed              = s2_speed_reg;
    end

    assign dx2_full = s3_rec_reg.dx * s3_rec_reg.dx;
    assign dy2_full = s3_rec_reg.dy * s3_rec_reg.dy;

    always_ff @(posedge clk)
    begin
        s3_rec_reg <= s3_rec_next;
        s4_rec_reg <= s3_rec_reg;
        s4_dx2_reg <= dx2_full[48:0];
        s4_dy2_reg <= dy2_full[48:0];
        s4_ar2_reg <= arrive_distance * arrive_distance;
    end

    always_comb
    begin
        push_data = s4_rec_reg;
        push_data.res.near_attractor =
            (({1'b0, s4_dx2_reg} + {1'b0, s4_dy2_reg}) < {2'b00, s4_ar2_reg});
    end

    assign push     = s4_vld_reg;
    assign inflight = 3'(s1_vld_reg) + 3'(s2_vld_reg) + 3'(s3_vld_reg) + 3'(s4_vld_reg);

endmodule

FILE: sv/pssu_norm.sv
// Pipelined vector normalizer: squares, bitwise square root, per-bit division.
module pssu_norm
    import pssu_pkg::*;
#(
    parameter int W  = 25,
    parameter int SW = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic signed [W-1:0]      in_x,
    input  logic signed [W-1:0]      in_y,
    input  logic [SW-1:0]            in_side,
    output logic                     out_vld,
    output logic signed [UNIT_W-1:0] out_x,
    output logic signed [UNIT_W-1:0] out_y,
    output logic [SW-1:0]            out_side
);

    localparam int SQW = 2 * W + 1;
    localparam int NW  = W + Q_BITS + 1;

    logic signed [2*W-1:0] xx_full, yy_full;

    logic                  a_vld_reg;
    logic [2*W-1:0]        a_xx_reg, a_yy_reg;
    logic signed [W-1:0]   a_x_reg, a_y_reg;
    logic [SW-1:0]         a_side_reg;

    logic                  sq_vld_reg  [0:W];
    logic [SQW-1:0]        sq_rem_reg  [0:W];
    logic [SQW-1:0]        sq_res_reg  [0:W];
    logic signed [W-1:0]   sq_x_reg    [0:W];
    logic signed [W-1:0]   sq_y_reg    [0:W];
    logic [SW-1:0]         sq_side_reg [0:W];

    logic                  dv_vld_reg  [0:Q_BITS];
    logic [NW-1:0]         dv_rx_reg   [0:Q_BITS];
    logic [NW-1:0]         dv_ry_reg   [0:Q_BITS];
    logic [Q_BITS-1:0]     dv_qx_reg   [0:Q_BITS];
    logic [Q_BITS-1:0]     dv_qy_reg   [0:Q_BITS];
    logic [W-1:0]          dv_den_reg  [0:Q_BITS];
    logic                  dv_nx_reg   [0:Q_BITS];
    logic                  dv_ny_reg   [0:Q_BITS];
    logic                  dv_zero_reg [0:Q_BITS];
    logic [SW-1:0]         dv_side_reg [0:Q_BITS];

    logic [W-1:0]          len;
    logic [W-1:0]          mag_x, mag_y;

    logic                      o_vld_reg;
    logic signed [UNIT_W-1:0]  o_x_reg, o_y_reg;
    logic [SW-1:0]             o_side_reg;

    assign xx_full = in_x * in_x;
    assign yy_full = in_y * in_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            o_vld_reg     <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= in_vld;
            sq_vld_reg[0] <= a_vld_reg;
            dv_vld_reg[0] <= sq_vld_reg[W];
            o_vld_reg     <= dv_vld_reg[Q_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_xx_reg       <= xx_full;
            a_yy_reg       <= yy_full;
            a_x_reg        <= in_x;
            a_y_reg        <= in_y;
            a_side_reg     <= in_side;
            sq_rem_reg[0]  <= {1'b0, a_xx_reg} + {1'b0, a_yy_reg};
            sq_res_reg[0]  <= '0;
            sq_x_reg[0]    <= a_x_reg;
            sq_y_reg[0]    <= a_y_reg;
            sq_side_reg[0] <= a_side_reg;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        localparam logic [SQW-1:0] SQ_BIT = SQW'(1) << (2 * (W - 1 - k));
        logic [SQW-1:0] trial;
        assign trial = sq_res_reg[k] + SQ_BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else if (en)
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_rem_reg[k] >= trial)
                begin
                    sq_rem_reg[k+1] <= sq_rem_reg[k] - trial;
                    sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + SQ_BIT;
                end
                else
                begin
                    sq_rem_reg[k+1] <= sq_rem_reg[k];
                    sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
                end
                sq_x_reg[k+1]    <= sq_x_reg[k];
                sq_y_reg[k+1]    <= sq_y_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    assign len   = sq_res_reg[W][W-1:0];
    assign mag_x = sq_x_reg[W][W-1] ? W'(-sq_x_reg[W]) : W'(sq_x_reg[W]);
    assign mag_y = sq_y_reg[W][W-1] ? W'(-sq_y_reg[W]) : W'(sq_y_reg[W]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rx_reg[0]   <= {mag_x, 16'd0} + NW'(len >> 1);
            dv_ry_reg[0]   <= {mag_y, 16'd0} + NW'(len >> 1);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_den_reg[0]  <= len;
            dv_nx_reg[0]   <= sq_x_reg[W][W-1];
            dv_ny_reg[0]   <= sq_y_reg[W][W-1];
            dv_zero_reg[0] <= (len == '0);
            dv_side_reg[0] <= sq_side_reg[W];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < Q_BITS; j++)
    begin : g_div
        localparam int SH = Q_BITS - 1 - j;
        logic [NW-1:0] trial;
        assign trial = NW'(dv_den_reg[j]) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else if (en)
                dv_vld_reg[j+1] <= dv_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (dv_rx_reg[j] >= trial)
                begin
                    dv_rx_reg[j+1] <= dv_rx_reg[j] - trial;
                    dv_qx_reg[j+1] <= dv_qx_reg[j] | (Q_BITS'(1) << SH);
                end
                else
                begin
                    dv_rx_reg[j+1] <= dv_rx_reg[j];
                    dv_qx_reg[j+1] <= dv_qx_reg[j];
                end
                if (dv_ry_reg[j] >= trial)
                begin
                    dv_ry_reg[j+1] <= dv_ry_reg[j] - trial;
                    dv_qy_reg[j+1] <= dv_qy_reg[j] | (Q_BITS'(1) << SH);
                end
                else
                begin
                    dv_ry_reg[j+1] <= dv_ry_reg[j];
                    dv_qy_reg[j+1] <= dv_qy_reg[j];
                end
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_nx_reg[j+1]   <= dv_nx_reg[j];
                dv_ny_reg[j+1]   <= dv_ny_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    // zero-length vector gives a zero unit vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dv_zero_reg[Q_BITS])
            begin
                o_x_reg <= '0;
                o_y_reg <= '0;
            end
            else
            begin
                o_x_reg <= dv_nx_reg[Q_BITS] ? -$signed({1'b0, dv_qx_reg[Q_BITS]})
                                             :  $signed({1'b0, dv_qx_reg[Q_BITS]});
                o_y_reg <= dv_ny_reg[Q_BITS] ? -$signed({1'b0, dv_qy_reg[Q_BITS]})
                                             :  $signed({1'b0, dv_qy_reg[Q_BITS]});
            end
            o_side_reg <= dv_side_reg[Q_BITS];
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_x    = o_x_reg;
    assign out_y    = o_y_reg;
    assign out_side = o_side_reg;

endmodule

FILE: sv/pssu_back.sv
// Back part: direction blend, renormalize, scale to speed, output register.
module pssu_back
    import pssu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [16:0]        blend_ratio,
    input  logic               q_empty,
    input  rec_t               q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] new_pos_x,
    output logic signed [23:0] new_pos_y,
    output logic signed [23:0] new_vel_x,
    output logic signed [23:0] new_vel_y,
    output logic [31:0]        new_age,
    output logic signed [23:0] trail_x,
    output logic signed [23:0] trail_y,
    output logic               near_attractor,
    output logic               expired
);

    logic        en;
    logic [16:0] r_eff, r_cmp;

    logic                     vu_vld, du_vld, bu_vld;
    logic signed [UNIT_W-1:0] ox, oy, gx, gy, fx, fy;
    logic [15:0]              vu_speed;
    res_t                     du_res;
    mid_t                     bu_mid;

    logic                     p_vld_reg;
    logic signed [35:0]       p_ox_reg, p_oy_reg, p_gx_reg, p_gy_reg;
    mid_t                     p_mid_reg;

    logic                     b_vld_reg;
    logic signed [UNIT_W-1:0] b_x_reg, b_y_reg;
    mid_t                     b_mid_reg;
    logic signed [47:0]       bx_full, by_full;

    logic                     f_vld_reg;
    logic signed [34:0]       f_x_reg, f_y_reg;
    res_t                     f_res_reg;

    logic                     out_vld_reg;
    logic signed [23:0]       out_vx_reg, out_vy_reg;
    res_t                     out_res_reg;

    // the whole back pipeline freezes while a finished transaction waits
    assign en    = !out_vld_reg || !out_stall;
    assign q_pop = en && !q_empty;

    assign r_eff = (blend_ratio > ONE_Q16) ? ONE_Q16 : blend_ratio;
    assign r_cmp = ONE_Q16 - r_eff;

    pssu_norm #(.W(25), .SW(16)) u_vel_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (!q_empty),
        .in_x     (25'(q_head.vel_x)),
        .in_y     (25'(q_head.vel_y)),
        .in_side  (q_head.speed),
        .out_vld  (vu_vld),
        .out_x    (ox),
        .out_y    (oy),
        .out_side (vu_speed)
    );

    pssu_norm #(.W(25), .SW($bits(res_t))) u_dir_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (!q_empty),
        .in_x     (q_head.dx),
        .in_y     (q_head.dy),
        .in_side  (q_head.res),
        .out_vld  (du_vld),
        .out_x    (gx),
        .out_y    (gy),
        .out_side (du_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg   <= vu_vld && du_vld;
            b_vld_reg   <= p_vld_reg;
            f_vld_reg   <= bu_vld;
            out_vld_reg <= f_vld_reg;
        end
    end

    assign bx_full = round_shr(48'(37'(p_ox_reg) + 37'(p_gx_reg)), 16);
    assign by_full = round_shr(48'(37'(p_oy_reg) + 37'(p_gy_reg)), 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ox_reg  <= ox * $signed({1'b0, r_eff});
            p_oy_reg  <= oy * $signed({1'b0, r_eff});
            p_gx_reg  <= gx * $signed({1'b0, r_cmp});
            p_gy_reg  <= gy * $signed({1'b0, r_cmp});
            p_mid_reg <= '{res: du_res, speed: vu_speed};
            b_x_reg   <= bx_full[UNIT_W-1:0];
            b_y_reg   <= by_full[UNIT_W-1:0];
            b_mid_reg <= p_mid_reg;
        end
    end

    pssu_norm #(.W(UNIT_W), .SW($bits(mid_t))) u_blend_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (b_vld_reg),
        .in_x     (b_x_reg),
        .in_y     (b_y_reg),
        .in_side  (b_mid_reg),
        .out_vld  (bu_vld),
        .out_x    (fx),
        .out_y    (fy),
        .out_side (bu_mid)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_x_reg     <= fx * $signed({1'b0, bu_mid.speed});
            f_y_reg     <= fy * $signed({1'b0, bu_mid.speed});
            f_res_reg   <= bu_mid.res;
            out_vx_reg  <= sat24(round_shr(48'(f_x_reg), 16));
            out_vy_reg  <= sat24(round_shr(48'(f_y_reg), 16));
            out_res_reg <= f_res_reg;
        end
    end

    assign out_valid      = out_vld_reg;
    assign new_pos_x      = out_res_reg.new_pos_x;
    assign new_pos_y      = out_res_reg.new_pos_y;
    assign new_vel_x      = out_vx_reg;
    assign new_vel_y      = out_vy_reg;
    assign new_age        = out_res_reg.new_age;
    assign trail_x        = out_res_reg.trail_x;
    assign trail_y        = out_res_reg.trail_y;
    assign near_attractor = out_res_reg.near_attractor;
    assign expired        = out_res_reg.expired;

endmodule

FILE: sv/particle_seek_steering_update_unit.sv
// Top level of the particle seek steering and ageing unit.
//
//  channel   direction  handshake                 payload
//  input     in         in_valid / in_stall       particle record, ten fields
//  output    out        out_valid / out_stall     updated particle, nine fields
//  config    in         cfg_wr_en                 cfg_index, cfg_data
//
// One transaction per clock cycle in steady state while out_stall is low; the back part
// runs three normalizer pipelines (25- and 18-step square root, 17-step divider each).
// Reset clears all valid bits, the queue and the configuration to its defaults.
// out_stall freezes the back pipeline; the front keeps accepting until the queue
// plus the four front stages hold QUEUE_DEPTH transactions.
module particle_seek_steering_update_unit
    import pssu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] vel_x,
    input  logic signed [23:0] vel_y,
    input  logic signed [23:0] attractor_x,
    input  logic signed [23:0] attractor_y,
    input  logic [15:0]        speed,
    input  logic [31:0]        age,
    input  logic [31:0]        lifetime,
    input  logic [15:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] new_pos_x,
    output logic signed [23:0] new_pos_y,
    output logic signed [23:0] new_vel_x,
    output logic signed [23:0] new_vel_y,
    output logic [31:0]        new_age,
    output logic signed [23:0] trail_x,
    output logic signed [23:0] trail_y,
    output logic               near_attractor,
    output logic               expired
);

    localparam int CW = $clog2(QUEUE_DEPTH) + 1;

    logic [16:0] blend_ratio_reg;
    logic [23:0] arrive_distance_reg;
    logic [15:0] screen_width_reg;
    logic [15:0] screen_height_reg;

    logic          accept;
    logic          push, pop, q_empty;
    rec_t          push_data, q_head;
    logic [2:0]    inflight;
    logic [CW-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_ratio_reg     <= BLEND_RATIO_RST;
            arrive_distance_reg <= ARRIVE_DISTANCE_RST;
            screen_width_reg    <= SCREEN_WIDTH_RST;
            screen_height_reg   <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BLEND_RATIO:     blend_ratio_reg     <= cfg_data[16:0];
                REG_ARRIVE_DISTANCE: arrive_distance_reg <= cfg_data;
                REG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data[15:0];
                REG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // hold input while every queue slot is spoken for
    assign in_stall = ((CW + 1)'(q_count) + (CW + 1)'(inflight)) >= (CW + 1)'(QUEUE_DEPTH);
    assign accept   = in_valid && !in_stall;

    pssu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .attractor_x     (attractor_x),
        .attractor_y     (attractor_y),
        .speed           (speed),
        .age             (age),
        .lifetime        (lifetime),
        .time_step       (time_step),
        .arrive_distance (arrive_distance_reg),
        .screen_width    (screen_width_reg),
        .screen_height   (screen_height_reg),
        .push            (push),
        .push_data       (push_data),
        .inflight        (inflight)
    );

    pssu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .count     (q_count)
    );

    pssu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .blend_ratio    (blend_ratio_reg),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .new_pos_x      (new_pos_x),
        .new_pos_y      (new_pos_y),
        .new_vel_x      (new_vel_x),
        .new_vel_y      (new_vel_y),
        .new_age        (new_age),
        .trail_x        (trail_x),
        .trail_y        (trail_y),
        .near_attractor (near_attractor),
        .expired        (expired)
    );

endmodule

FILE: sv/pssu_checker.sv
// Port-level checks for the particle steering unit, bound to the top level.
module pssu_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [23:0] new_pos_x,
    input logic signed [23:0] new_pos_y,
    input logic signed [23:0] new_vel_x,
    input logic [31:0]        new_age,
    input logic               expired
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_pos_x) && $stable(new_vel_x)
                                   && $stable(new_age) && $stable(expired))
        else $error("stalled output transaction changed");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

    a_negative_expires: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (new_pos_x[23] || new_pos_y[23]) |-> expired)
        else $error("particle left screen at negative position but not expired");

endmodule

bind particle_seek_steering_update_unit pssu_checker u_pssu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_pos_x (new_pos_x),
    .new_pos_y (new_pos_y),
    .new_vel_x (new_vel_x),
    .new_age   (new_age),
    .expired   (expired)
);
